@@ rtl/tts_pkg.sv @@
// package for the text terminal scrollback core
// request codes, register indexes, character codes, payload structs and default parameters
// no dependencies
`timescale 1ns / 1ps
package tts_pkg;
    localparam int DEF_COLUMNS      = 80;
    localparam int DEF_VISIBLE_ROWS = 25;
    localparam int DEF_STORE_ROWS   = 64;
    localparam int DEF_SCREENS      = 4;

    localparam logic [2:0] REQ_PUT   = 3'd0;
    localparam logic [2:0] REQ_NL    = 3'd1;
    localparam logic [2:0] REQ_BS    = 3'd2;
    localparam logic [2:0] REQ_CLEAR = 3'd3;
    localparam logic [2:0] REQ_READ  = 3'd4;

    localparam logic [1:0] CFG_SCREEN  = 2'd0;
    localparam logic [1:0] CFG_FILL    = 2'd1;
    localparam logic [1:0] CFG_PROMPT  = 2'd2;
    localparam logic [1:0] CFG_NEWLINE = 2'd3;

    localparam logic [7:0] CH_BLANK   = 8'd32;
    localparam logic [7:0] CH_TILDE   = 8'd126;
    localparam logic [7:0] CH_NEWLINE = 8'd10;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [7:0]  char_code;
        logic [7:0]  char_color;
        logic [12:0] cell_index;
    } tts_in_t;

    typedef struct packed {
        logic [12:0] cursor_offset;
        logic [5:0]  rows_used;
        logic        view_scrolled;
        logic        buffer_shifted;
        logic        accepted;
        logic [15:0] cell_data;
    } tts_out_t;
endpackage

@@ rtl/text_terminal_scrollback_core.sv @@
// text terminal scrollback core: sequenced cell store per screen
// depends on tts_pkg
// usage:
//   in_valid/in_ready carry one request (tts_in_t); out_valid/out_ready
//   return one result (tts_out_t) per request. cfg_valid/cfg_ready with
//   cfg_index/cfg_data write the four registers; the user is to write them
//   only while the block is idle, the block itself does not enforce it.
//   all store traffic goes through one memory with a write port and a
//   registered read port, under a small sequencer.
//   read, backspace and a put char that stays on its row pass the read
//   wait, execute and output states; a row step adds the step state; new
//   line first pads the rest of the row, then steps; a row shift walks the
//   store, reading and writing each moved cell and blanking the last row;
//   clear writes every cell of the screen. the next request is taken only
//   after the result is taken, so the block handles one request at a time.
//   after reset a clearing pass writes zero to all SCREENS*STORE_ROWS*
//   COLUMNS cells (20480 at defaults) before in_ready rises.
//   the result sits in an output register; while the receiver stalls the
//   block holds it and accepts no new request.
`timescale 1ns / 1ps
module text_terminal_scrollback_core #(
    parameter int COLUMNS      = tts_pkg::DEF_COLUMNS,
    parameter int VISIBLE_ROWS = tts_pkg::DEF_VISIBLE_ROWS,
    parameter int STORE_ROWS   = tts_pkg::DEF_STORE_ROWS,
    parameter int SCREENS      = tts_pkg::DEF_SCREENS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  tts_pkg::tts_in_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output tts_pkg::tts_out_t out_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [7:0]       cfg_data
);
    import tts_pkg::*;

    localparam int CELLS = COLUMNS * STORE_ROWS;
    localparam int CW    = $clog2(CELLS + 1);
    localparam int CIW   = $clog2(CELLS);
    localparam int SW    = (SCREENS > 1) ? $clog2(SCREENS) : 1;
    localparam int RW    = $clog2(STORE_ROWS);
    localparam int TOTAL = CELLS * SCREENS;
    localparam int AW    = $clog2(TOTAL);
    localparam int KW    = $clog2(COLUMNS + 1);

    typedef enum logic [10:0] {
        ST_INIT  = 11'b00000000001,
        ST_IDLE  = 11'b00000000010,
        ST_RDWT  = 11'b00000000100,
        ST_EXEC  = 11'b00000001000,
        ST_PAD   = 11'b00000010000,
        ST_STEP  = 11'b00000100000,
        ST_SHRD  = 11'b00001000000,
        ST_SHWR  = 11'b00010000000,
        ST_BLANK = 11'b00100000000,
        ST_CLR   = 11'b01000000000,
        ST_OUT   = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    logic [15:0] mem [TOTAL];
    logic        mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [15:0] mem_wdata, mem_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        mem_rdata_reg <= mem[mem_raddr];
    end

    logic [1:0]  screen_reg;
    logic [7:0]  fill_reg, prompt_reg, newline_reg;
    logic [RW-1:0] rows_reg [SCREENS];
    logic [CW-1:0] cursor_reg, cursor_next;
    logic [RW-1:0] rows_new;
    logic        rows_we;
    tts_in_t     req_reg;
    logic [CIW-1:0] ptr_reg, ptr_next;       // walk pointer within screen
    logic [AW-1:0]  init_reg, init_next;
    logic [KW-1:0]  col_reg, col_next;       // cursor % COLUMNS
    logic        shifted_reg, shifted_next, ok_reg, ok_next;
    logic [15:0] data_reg, data_next;
    tts_out_t    out_reg;
    logic        outv_reg;

    logic [SW-1:0] scr;
    logic [AW-1:0] base;
    always_comb
    begin
        if (32'(screen_reg) >= SCREENS)
            scr = SW'(SCREENS - 1);
        else
            scr = SW'(screen_reg);
        base = AW'(32'(scr) * CELLS);
    end

    logic [RW-1:0] rows_cur;
    assign rows_cur = rows_reg[scr];

    logic printable, rows_full;
    assign printable = req_reg.char_code >= CH_BLANK && req_reg.char_code <= CH_TILDE;
    assign rows_full = 32'(rows_cur) >= STORE_ROWS - 1;

    assign in_ready  = (state_reg == ST_IDLE) && !outv_reg;
    assign cfg_ready = 1'b1;
    assign out_valid = outv_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_reg  <= 2'd0;
            fill_reg    <= 8'd14;
            prompt_reg  <= 8'd2;
            newline_reg <= 8'd15;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_SCREEN:  screen_reg  <= cfg_data[1:0];
                CFG_FILL:    fill_reg    <= cfg_data;
                CFG_PROMPT:  prompt_reg  <= cfg_data;
                CFG_NEWLINE: newline_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cursor_next  = cursor_reg;
        ptr_next     = ptr_reg;
        init_next    = init_reg;
        col_next     = col_reg;
        shifted_next = shifted_reg;
        ok_next      = ok_reg;
        data_next    = data_reg;
        mem_we       = 1'b0;
        mem_waddr    = base + AW'(cursor_reg);
        mem_wdata    = {newline_reg, CH_BLANK};
        mem_raddr    = base + AW'(cursor_reg);
        rows_we      = 1'b0;
        rows_new     = rows_cur;
        unique case (state_reg)
            ST_INIT:
            begin
                mem_we    = 1'b1;
                mem_waddr = init_reg;
                mem_wdata = 16'd0;
                init_next = init_reg + 1'b1;
                if (32'(init_reg) == TOTAL - 1)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                shifted_next = 1'b0;
                ok_next      = 1'b1;
                data_next    = 16'd0;
                // read cell before cursor, or requested cell
                if (in_data.req_type == REQ_READ)
                    mem_raddr = base + AW'(in_data.cell_index);
                else
                    mem_raddr = base + AW'(cursor_reg - 1'b1);
                if (in_valid && in_ready)
                    state_next = ST_RDWT;
            end
            ST_RDWT:
            begin
                // keep the same address so the read data is valid in exec
                if (req_reg.req_type == REQ_READ)
                    mem_raddr = base + AW'(req_reg.cell_index);
                else
                    mem_raddr = base + AW'(cursor_reg - 1'b1);
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                state_next = ST_OUT;
                case (req_reg.req_type) inside
                    REQ_PUT, REQ_NL:
                    begin
                        if (req_reg.req_type == REQ_NL || req_reg.char_code == CH_NEWLINE)
                        begin
                            if (32'(cursor_reg) < CELLS)
                                state_next = ST_PAD;
                            else
                                state_next = ST_STEP;
                        end
                        else if (printable && 32'(cursor_reg) < CELLS)
                        begin
                            mem_we      = 1'b1;
                            mem_wdata   = {req_reg.char_color, req_reg.char_code};
                            cursor_next = cursor_reg + 1'b1;
                            if (32'(col_reg) == COLUMNS - 1)
                            begin
                                col_next   = '0;
                                state_next = ST_STEP;
                            end
                            else
                                col_next = col_reg + 1'b1;
                        end
                        else
                            ok_next = 1'b0;
                    end
                    REQ_BS:
                    begin
                        if (cursor_reg == '0 || 32'(cursor_reg) > CELLS ||
                            mem_rdata_reg == {prompt_reg, CH_BLANK})
                            ok_next = 1'b0;
                        else
                        begin
                            cursor_next = cursor_reg - 1'b1;
                            mem_we      = 1'b1;
                            mem_waddr   = base + AW'(cursor_reg - 1'b1);
                            mem_wdata   = {fill_reg, CH_BLANK};
                            if (col_reg == '0)
                            begin
                                col_next = KW'(COLUMNS - 1);
                                if (!rows_full && rows_cur != '0)
                                begin
                                    rows_we  = 1'b1;
                                    rows_new = rows_cur - 1'b1;
                                end
                            end
                            else
                                col_next = col_reg - 1'b1;
                        end
                    end
                    REQ_CLEAR:
                    begin
                        ptr_next   = '0;
                        state_next = ST_CLR;
                    end
                    REQ_READ:
                    begin
                        if (32'(req_reg.cell_index) < CELLS)
                            data_next = mem_rdata_reg;
                    end
                    default:
                        ok_next = 1'b0;
                endcase
            end
            ST_PAD:
            begin
                mem_we      = 1'b1;
                cursor_next = cursor_reg + 1'b1;
                if (32'(col_reg) == COLUMNS - 1)
                begin
                    col_next   = '0;
                    state_next = ST_STEP;
                end
                else
                    col_next = col_reg + 1'b1;
            end
            ST_STEP:
            begin
                if (rows_full)
                begin
                    shifted_next = 1'b1;
                    ptr_next     = '0;
                    if (32'(cursor_reg) >= COLUMNS)
                        cursor_next = cursor_reg - CW'(COLUMNS);
                    else
                        cursor_next = '0;
                    state_next = ST_SHRD;
                end
                else
                begin
                    rows_we    = 1'b1;
                    rows_new   = rows_cur + 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_SHRD:
            begin
                mem_raddr  = base + AW'(ptr_reg) + AW'(COLUMNS);
                state_next = ST_SHWR;
            end
            ST_SHWR:
            begin
                mem_we    = 1'b1;
                mem_waddr = base + AW'(ptr_reg);
                mem_wdata = mem_rdata_reg;
                ptr_next  = ptr_reg + 1'b1;
                if (32'(ptr_reg) == CELLS - COLUMNS - 1)
                    state_next = ST_BLANK;
                else
                    state_next = ST_SHRD;
            end
            ST_BLANK:
            begin
                mem_we    = 1'b1;
                mem_waddr = base + AW'(ptr_reg);
                mem_wdata = {fill_reg, CH_BLANK};
                ptr_next  = ptr_reg + 1'b1;
                if (32'(ptr_reg) == CELLS - 1)
                    state_next = ST_OUT;
            end
            ST_CLR:
            begin
                mem_we    = 1'b1;
                mem_waddr = base + AW'(ptr_reg);
                mem_wdata = {fill_reg, CH_BLANK};
                ptr_next  = ptr_reg + 1'b1;
                if (32'(ptr_reg) == CELLS - 1)
                begin
                    cursor_next = '0;
                    col_next    = '0;
                    rows_we     = 1'b1;
                    rows_new    = '0;
                    state_next  = ST_OUT;
                end
            end
            ST_OUT:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_INIT;
            init_reg    <= '0;
            cursor_reg  <= '0;
            col_reg     <= '0;
            outv_reg    <= 1'b0;
            for (int i = 0; i < SCREENS; i++)
                rows_reg[i] <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            init_reg   <= init_next;
            cursor_reg <= cursor_next;
            col_reg    <= col_next;
            if (rows_we)
                rows_reg[scr] <= rows_new;
            if (state_reg == ST_OUT)
                outv_reg <= 1'b1;
            else if (out_ready)
                outv_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg     <= ptr_next;
        shifted_reg <= shifted_next;
        ok_reg      <= ok_next;
        data_reg    <= data_next;
        if (in_valid && in_ready)
            req_reg <= in_data;
        if (state_reg == ST_OUT)
        begin
            out_reg.cursor_offset  <= 13'(cursor_reg);
            out_reg.rows_used      <= 6'(rows_cur);
            out_reg.view_scrolled  <= 32'(rows_cur) >= VISIBLE_ROWS;
            out_reg.buffer_shifted <= shifted_reg;
            out_reg.accepted       <= ok_reg;
            out_reg.cell_data      <= data_reg;
        end
    end

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cursor_reg) <= CELLS)
        else $error("cursor beyond store");
    a_col_match: assert property (@(posedge clk) disable iff (!rst_n)
        32'(col_reg) == 32'(cursor_reg) % COLUMNS || 32'(cursor_reg) == CELLS)
        else $error("column tracker out of step");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !in_ready)
        else $error("request taken while busy");
    a_out_after: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT) |=> out_valid)
        else $error("result not raised");
    a_rows_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(rows_cur) <= STORE_ROWS - 1)
        else $error("row count overflow");
endmodule
